FILE: sv/cec_pkg.sv
package cec_pkg;

	localparam int unsigned CountWidth = 8;
	localparam int unsigned LevelWidth = 8;
	localparam int unsigned CfgIndexWidth = 1;

	localparam logic [CountWidth-1:0] CountMax = 8'hFF;
	localparam logic [LevelWidth-1:0] WarningLevelReset = 8'd96;
	localparam logic [LevelWidth-1:0] PassiveLevelReset = 8'd128;

	typedef enum logic [1:0] {
		OP_ERROR   = 2'd0,
		OP_SUCCESS = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_WARNING_LEVEL = 1'b0,
		CFG_PASSIVE_LEVEL = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [CountWidth-1:0] rx_count;
		logic [CountWidth-1:0] tx_count;
		logic                  bus_off;
	} counters_t;

	typedef struct packed {
		logic any_warning;
		logic rx_warning;
		logic tx_warning;
		logic rx_passive;
		logic tx_passive;
		logic bus_off;
	} flags_t;

endpackage

FILE: sv/cec_ifs.sv
interface cec_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic       is_transmit_error;
	logic [7:0] error_amount;

	modport source (output valid, output op, output is_transmit_error,
		output error_amount, input ready);
	modport sink (input valid, input op, input is_transmit_error,
		input error_amount, output ready);
endinterface

interface cec_status_if;
	logic       valid;
	logic       ready;
	logic [7:0] receive_count;
	logic [7:0] transmit_count;
	logic       any_warning;
	logic       receive_warning;
	logic       transmit_warning;
	logic       receive_passive;
	logic       transmit_passive;
	logic       bus_off_flag;

	modport source (output valid, output receive_count, output transmit_count,
		output any_warning, output receive_warning, output transmit_warning,
		output receive_passive, output transmit_passive, output bus_off_flag,
		input ready);
	modport sink (input valid, input receive_count, input transmit_count,
		input any_warning, input receive_warning, input transmit_warning,
		input receive_passive, input transmit_passive, input bus_off_flag,
		output ready);
endinterface

FILE: sv/cec_update.sv
module cec_update
	import cec_pkg::*;
(
	input  op_t                   op,
	input  logic                  tx_sel,
	input  logic [CountWidth-1:0] amount,
	input  counters_t             cur,
	input  logic [LevelWidth-1:0] warning_level,
	input  logic [LevelWidth-1:0] passive_level,
	output counters_t             nxt,
	output flags_t                flags
);

	logic [CountWidth:0]   sum;
	logic [CountWidth-1:0] sel_count;
	logic                  sum_ovf;
	logic [CountWidth-1:0] sat_sum;
	logic                  rx_warn_hit;
	logic                  tx_warn_hit;
	logic                  rx_pass_hit;
	logic                  tx_pass_hit;

	// One adder serves whichever counter the error selects.
	assign sel_count = tx_sel ? cur.tx_count : cur.rx_count;
	assign sum       = {1'b0, sel_count} + {1'b0, amount};
	assign sum_ovf   = sum[CountWidth];
	assign sat_sum   = sum_ovf ? CountMax : sum[CountWidth-1:0];

	always_comb begin
		nxt = cur;
		unique case (op)
			OP_ERROR: begin
				if (tx_sel) begin
					nxt.tx_count = sat_sum;
					if (sum_ovf) begin
						nxt.bus_off = 1'b1;
					end
				end else begin
					nxt.rx_count = sat_sum;
				end
			end
			OP_SUCCESS: begin
				if (cur.tx_count != '0) begin
					nxt.tx_count = cur.tx_count - CountWidth'(1);
				end
			end
			OP_CLEAR: begin
				nxt = '0;
			end
			OP_NONE: begin
				nxt = cur;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign rx_warn_hit = nxt.rx_count >= warning_level;
	assign tx_warn_hit = nxt.tx_count >= warning_level;
	assign rx_pass_hit = nxt.rx_count >= passive_level;
	assign tx_pass_hit = nxt.tx_count >= passive_level;

	always_comb begin
		flags.any_warning = rx_warn_hit | tx_warn_hit;
		flags.rx_warning  = rx_warn_hit & ~rx_pass_hit;
		flags.tx_warning  = tx_warn_hit & ~tx_pass_hit;
		flags.rx_passive  = rx_pass_hit;
		flags.tx_passive  = tx_pass_hit & ~nxt.bus_off;
		flags.bus_off     = nxt.bus_off;
	end

endmodule

FILE: sv/can_error_counter_status.sv
// CAN transmit/receive error counters with derived fault-confinement flags.
// Each command word (error event, successful transmission, clear) updates
// the counters and yields exactly one status word holding both counts and
// the warning, passive and bus-off flags as they stand after the update.
// The accepting edge loads the command register, and the word moves on into
// the status register once that register is empty or being drained. Words
// flow at one per cycle while the status side takes them, through the single
// saturating 8-bit adder and level comparators between the two registers;
// the command side keeps accepting while a status word waits downstream, and
// stalls only when both registers are full and the status word is not taken.
// Write warning_level (index 0) and passive_level (index 1) only while idle.
module can_error_counter_status
	import cec_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [LevelWidth-1:0]    cfg_data,
	cec_cmd_if.sink                  cmd,
	cec_status_if.source             status
);

	// Configuration levels
	logic [LevelWidth-1:0] warning_level_q;
	logic [LevelWidth-1:0] passive_level_q;

	// Command register
	logic                  valid_s1;
	op_t                   op_s1;
	logic                  tx_sel_s1;
	logic [CountWidth-1:0] amount_s1;

	// Counter state
	counters_t             cnt_q;
	counters_t             cnt_nxt;
	flags_t                flags_nxt;

	// Status register
	logic                  valid_s2;
	counters_t             cnt_s2;
	flags_t                flags_s2;

	logic                  advance;
	logic                  cmd_take;

	// Move a word into the status register when it is empty or being drained.
	assign advance  = valid_s1 & (~valid_s2 | status.ready);
	assign cmd.ready = ~valid_s1 | advance;
	assign cmd_take = cmd.valid & cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warning_level_q <= WarningLevelReset;
			passive_level_q <= PassiveLevelReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WARNING_LEVEL: warning_level_q <= cfg_data;
				CFG_PASSIVE_LEVEL: passive_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the command word until it advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_s1     <= op_t'(cmd.op);
			tx_sel_s1 <= cmd.is_transmit_error;
			amount_s1 <= cmd.error_amount;
		end
	end

	cec_update u_update (
		.op            (op_s1),
		.tx_sel        (tx_sel_s1),
		.amount        (amount_s1),
		.cur           (cnt_q),
		.warning_level (warning_level_q),
		.passive_level (passive_level_q),
		.nxt           (cnt_nxt),
		.flags         (flags_nxt)
	);

	// Commit the counters only when the result is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (status.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cnt_s2   <= cnt_nxt;
			flags_s2 <= flags_nxt;
		end
	end

	assign status.valid            = valid_s2;
	assign status.receive_count    = cnt_s2.rx_count;
	assign status.transmit_count   = cnt_s2.tx_count;
	assign status.any_warning      = flags_s2.any_warning;
	assign status.receive_warning  = flags_s2.rx_warning;
	assign status.transmit_warning = flags_s2.tx_warning;
	assign status.receive_passive  = flags_s2.rx_passive;
	assign status.transmit_passive = flags_s2.tx_passive;
	assign status.bus_off_flag     = flags_s2.bus_off;

	// Counters change only when a word advances.
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cnt_q))
		else $error("counters changed without an advancing word");

	// Bus-off is only entered with the transmit counter saturated.
	a_bus_off_sat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cnt_q.bus_off) |-> cnt_q.tx_count == CountMax)
		else $error("bus-off latched without saturated transmit counter");

	// Transmit passive is suppressed while bus-off.
	a_tx_passive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(flags_s2.tx_passive && flags_s2.bus_off))
		else $error("transmit passive reported while bus-off");

	// A captured status word mirrors the committed counters.
	a_s2_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> cnt_s2 == cnt_q)
		else $error("status word does not match counter state");

endmodule

FILE: tb/tb_can_error_counter_status.sv
`timescale 1ns / 1ps

module tb_can_error_counter_status;
	import cec_pkg::*;

	// One status word as the block reports it: both counts and the six flags.
	typedef struct packed {
		logic [CountWidth-1:0] rx_count;
		logic [CountWidth-1:0] tx_count;
		flags_t                flags;
	} status_word_t;

	// Fault-confinement predictor plus the queue of status words still owed.
	class counter_scoreboard;
		logic [CountWidth-1:0] rx_errors;
		logic [CountWidth-1:0] tx_errors;
		logic                  bus_off;
		logic [LevelWidth-1:0] warning_level;
		logic [LevelWidth-1:0] passive_level;
		status_word_t          owed_words[$];
		int                    mismatches;

		function new();
			rx_errors     = '0;
			tx_errors     = '0;
			bus_off       = 1'b0;
			warning_level = WarningLevelReset;
			passive_level = PassiveLevelReset;
			mismatches    = 0;
		endfunction

		function void set_level(cfg_index_t idx, logic [LevelWidth-1:0] value);
			if (idx == CFG_WARNING_LEVEL) begin
				warning_level = value;
			end else begin
				passive_level = value;
			end
		endfunction

		// Apply one accepted command word and queue the status it must produce.
		function void note_command(op_t op, logic tx_sel, logic [7:0] amount);
			logic [CountWidth:0] sum;
			status_word_t        word;
			case (op)
				OP_ERROR: begin
					if (tx_sel) begin
						sum = {1'b0, tx_errors} + {1'b0, amount};
						if (sum > {1'b0, CountMax}) begin
							tx_errors = CountMax;
							bus_off   = 1'b1;
						end else begin
							tx_errors = sum[CountWidth-1:0];
						end
					end else begin
						sum = {1'b0, rx_errors} + {1'b0, amount};
						rx_errors = (sum > {1'b0, CountMax}) ? CountMax : sum[CountWidth-1:0];
					end
				end
				OP_SUCCESS: begin
					if (tx_errors != '0) tx_errors = tx_errors - CountWidth'(1);
				end
				OP_CLEAR: begin
					rx_errors = '0;
					tx_errors = '0;
					bus_off   = 1'b0;
				end
				default: ;
			endcase
			word.rx_count         = rx_errors;
			word.tx_count         = tx_errors;
			word.flags.any_warning = (rx_errors >= warning_level) ||
				(tx_errors >= warning_level);
			word.flags.rx_warning = (rx_errors >= warning_level) && (rx_errors < passive_level);
			word.flags.tx_warning = (tx_errors >= warning_level) && (tx_errors < passive_level);
			word.flags.rx_passive = (rx_errors >= passive_level);
			word.flags.tx_passive = (tx_errors >= passive_level) && !bus_off;
			word.flags.bus_off    = bus_off;
			owed_words.push_back(word);
		endfunction

		task report(string msg);
			// keep the log readable when a broken block mismatches on every word
			if (mismatches < 40) $display("%0t mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		// Compare an accepted status word with the oldest one owed.
		task check_status(status_word_t seen);
			status_word_t want;
			if (owed_words.size() == 0) begin
				report("status word arrived with none outstanding");
				return;
			end
			want = owed_words.pop_front();
			if (seen.rx_count !== want.rx_count)
				report($sformatf("receive_count %0d, want %0d", seen.rx_count, want.rx_count));
			if (seen.tx_count !== want.tx_count)
				report($sformatf("transmit_count %0d, want %0d", seen.tx_count, want.tx_count));
			if (seen.flags.any_warning !== want.flags.any_warning)
				report($sformatf("any_warning %b, want %b", seen.flags.any_warning,
					want.flags.any_warning));
			if (seen.flags.rx_warning !== want.flags.rx_warning)
				report($sformatf("receive_warning %b, want %b", seen.flags.rx_warning,
					want.flags.rx_warning));
			if (seen.flags.tx_warning !== want.flags.tx_warning)
				report($sformatf("transmit_warning %b, want %b", seen.flags.tx_warning,
					want.flags.tx_warning));
			if (seen.flags.rx_passive !== want.flags.rx_passive)
				report($sformatf("receive_passive %b, want %b", seen.flags.rx_passive,
					want.flags.rx_passive));
			if (seen.flags.tx_passive !== want.flags.tx_passive)
				report($sformatf("transmit_passive %b, want %b", seen.flags.tx_passive,
					want.flags.tx_passive));
			if (seen.flags.bus_off !== want.flags.bus_off)
				report($sformatf("bus_off_flag %b, want %b", seen.flags.bus_off,
					want.flags.bus_off));
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [LevelWidth-1:0]    cfg_data;

	cec_cmd_if    cmd_if ();
	cec_status_if status_if ();

	counter_scoreboard sb;

	// Idling switches for each side; cleared together for the long no-gap stretch.
	bit send_idling = 1'b1;
	bit recv_idling = 1'b1;
	int commands_taken = 0;

	can_error_counter_status u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_if),
		.status    (status_if)
	);

	// 20 ns clock: low then high.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Give up after a generous fixed time; a correct run ends well before this.
	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

	// Sample both handshakes at the rising edge, before the block's registers move.
	always @(posedge clk) begin
		status_word_t seen;
		if (arst_n && cmd_if.valid && cmd_if.ready) begin
			sb.note_command(op_t'(cmd_if.op), cmd_if.is_transmit_error, cmd_if.error_amount);
			commands_taken++;
		end
		if (arst_n && status_if.valid && status_if.ready) begin
			seen.rx_count         = status_if.receive_count;
			seen.tx_count         = status_if.transmit_count;
			seen.flags.any_warning = status_if.any_warning;
			seen.flags.rx_warning = status_if.receive_warning;
			seen.flags.tx_warning = status_if.transmit_warning;
			seen.flags.rx_passive = status_if.receive_passive;
			seen.flags.tx_passive = status_if.transmit_passive;
			seen.flags.bus_off    = status_if.bus_off_flag;
			sb.check_status(seen);
		end
	end

	// Status receiver: outside the no-gap phase drop ready about a quarter of the
	// time, and once hold it low for a long stretch while commands keep coming so
	// both registers fill and the command side has to stall.
	initial begin
		int hold_left;
		bit held_once;
		hold_left = 0;
		held_once = 1'b0;
		status_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				status_if.ready = 1'b0;
				hold_left--;
			end else if (!held_once && commands_taken >= 150) begin
				held_once = 1'b1;
				hold_left = 80;
				status_if.ready = 1'b0;
			end else begin
				status_if.ready = !(recv_idling && $urandom_range(0, 99) < 25);
			end
		end
	end

	// Offer one command word and hold it until the block takes it.
	task send_command(op_t op, logic tx_sel, logic [7:0] amount);
		@(negedge clk);
		while (send_idling && $urandom_range(0, 99) < 25) begin
			cmd_if.valid = 1'b0;
			@(negedge clk);
		end
		cmd_if.valid             = 1'b1;
		cmd_if.op                = op;
		cmd_if.is_transmit_error = tx_sel;
		cmd_if.error_amount      = amount;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
	endtask

	// Stop offering and wait until every owed status word has come back.
	task drain();
		int guard;
		guard = 0;
		@(negedge clk);
		cmd_if.valid = 1'b0;
		while (sb.owed_words.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Write one level register; only called with the block drained.
	task write_level(cfg_index_t idx, logic [LevelWidth-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		sb.set_level(idx, value);
	endtask

	// Mostly small error amounts so the counters walk through the warning and
	// passive bands; now and then a large or fully random one to saturate.
	function logic [7:0] pick_amount();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return 8'($urandom_range(0, 255));
		if (r == 2) return 8'($urandom_range(200, 255));
		return 8'($urandom_range(0, 12));
	endfunction

	task run_random(int count);
		int   r;
		op_t  op;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 55) op = OP_ERROR;
			else if (r < 85) op = OP_SUCCESS;
			else if (r < 90) op = OP_CLEAR;
			else op = OP_NONE;
			send_command(op, 1'($urandom_range(0, 1)), pick_amount());
		end
	endtask

	initial begin
		logic [LevelWidth-1:0] warn_set[10];
		logic [LevelWidth-1:0] pass_set[10];
		int                    phase_len[10];
		sb = new();

		// Hold every input at a known value from time zero.
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = CFG_WARNING_LEVEL;
		cfg_data                 = '0;
		cmd_if.valid             = 1'b0;
		cmd_if.op                = OP_NONE;
		cmd_if.is_transmit_error = 1'b0;
		cmd_if.error_amount      = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset levels: saturation, bus-off entry, success
		// while bus-off, ignored fields, the no-op opcode, and the level edges.
		send_command(OP_NONE, 1'b1, 8'hFF);
		send_command(OP_ERROR, 1'b0, 8'd0);
		send_command(OP_ERROR, 1'b0, 8'd255);
		send_command(OP_ERROR, 1'b0, 8'd1);
		send_command(OP_ERROR, 1'b1, 8'd200);
		send_command(OP_ERROR, 1'b1, 8'd55);
		send_command(OP_ERROR, 1'b1, 8'd1);
		send_command(OP_SUCCESS, 1'b1, 8'd255);
		send_command(OP_ERROR, 1'b1, 8'd0);
		send_command(OP_ERROR, 1'b1, 8'd255);
		send_command(OP_NONE, 1'b0, 8'd170);
		send_command(OP_CLEAR, 1'b1, 8'd255);
		send_command(OP_SUCCESS, 1'b0, 8'd85);
		send_command(OP_ERROR, 1'b1, 8'd95);
		send_command(OP_ERROR, 1'b1, 8'd1);
		send_command(OP_ERROR, 1'b1, 8'd31);
		send_command(OP_ERROR, 1'b1, 8'd1);
		send_command(OP_SUCCESS, 1'b1, 8'd0);
		send_command(OP_ERROR, 1'b0, 8'd95);
		send_command(OP_ERROR, 1'b0, 8'd1);
		send_command(OP_ERROR, 1'b0, 8'd32);
		send_command(OP_CLEAR, 1'b0, 8'd0);

		// Phase plan: reset levels, both extremes, crossed and equal levels,
		// two random settings, then back to the reset values.
		warn_set  = '{8'd96, 8'd0,   8'd255, 8'd0,   8'd255, 8'd128, 8'd100, 8'd0, 8'd0, 8'd96};
		pass_set  = '{8'd128, 8'd0,  8'd255, 8'd255, 8'd0,   8'd96,  8'd100, 8'd0, 8'd0, 8'd128};
		phase_len = '{250, 150, 200, 250, 150, 200, 150, 150, 150, 150};
		warn_set[7] = 8'($urandom_range(0, 255));
		pass_set[7] = 8'($urandom_range(0, 255));
		warn_set[8] = 8'($urandom_range(0, 127));
		pass_set[8] = 8'($urandom_range(128, 255));

		for (int p = 0; p < 10; p++) begin
			if (p != 0) begin
				drain();
				write_level(CFG_WARNING_LEVEL, warn_set[p]);
				write_level(CFG_PASSIVE_LEVEL, pass_set[p]);
			end
			// the fourth phase runs with no gaps on either side
			send_idling = (p != 3);
			recv_idling = (p != 3);
			run_random(phase_len[p]);
		end

		drain();
		repeat (4) @(posedge clk);
		if (sb.owed_words.size() != 0)
			sb.report($sformatf("%0d status words never arrived", sb.owed_words.size()));

		if (sb.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
